// ===== rtl/core/spr_pkg.sv =====
// shared types and constants of the shortest path relaxation block
package spr_pkg;

	localparam int DIST_W   = 48;
	localparam int WEIGHT_W = 32;
	localparam int NODE_W   = 6;
	localparam int NCOUNT_W = 7;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST  = 7'd64;
	localparam logic [NODE_W-1:0]   SOURCE_NODE_RST = 6'd0;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_NODE_COUNT  = 1'b0;
	localparam reg_idx_t REG_SOURCE_NODE = 1'b1;

	typedef struct packed {
		logic [NCOUNT_W-1:0] node_count;
		logic [NODE_W-1:0]   source_node;
	} cfg_t;

	typedef struct packed {
		logic [NODE_W-1:0]          from_node;
		logic [NODE_W-1:0]          to_node;
		logic signed [WEIGHT_W-1:0] weight;
	} edge_rec_t;

endpackage

// ===== rtl/core/spr_ram.sv =====
// generic single write port ram with registered read
module spr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/spr_relax_unit.sv =====
// saturating candidate adder and improvement compare shared by all edge visits
module spr_relax_unit (
	input  logic signed [spr_pkg::DIST_W-1:0]   dist_a,
	input  logic signed [spr_pkg::WEIGHT_W-1:0] weight,
	output logic signed [spr_pkg::DIST_W-1:0]   cand,
	input  logic signed [spr_pkg::DIST_W-1:0]   cand_in,
	input  logic signed [spr_pkg::DIST_W-1:0]   dist_b,
	input  logic                                reached_b,
	output logic                                improve
);
	import spr_pkg::*;

	localparam int SUM_W = DIST_W + 1;

	logic signed [SUM_W-1:0] sum;

	always_comb begin
		sum = SUM_W'(dist_a) + SUM_W'(weight);
		// clamp to the signed 48 bit range
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			cand = sum[SUM_W-1] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
		end else begin
			cand = sum[DIST_W-1:0];
		end
	end

	assign improve = !reached_b || (dist_b > cand_in);

endmodule

// ===== rtl/core/spr_apb_regs.sv =====
// apb configuration registers: node count and source node
module spr_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [spr_pkg::ADDR_W-1:0]  paddr,
	input  logic [spr_pkg::DATA_W-1:0]  pwdata,
	output logic [spr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output spr_pkg::cfg_t               cfg
);
	import spr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = paddr[2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_count  <= NODE_COUNT_RST;
			cfg_q.source_node <= SOURCE_NODE_RST;
		end else if (wr) begin
			case (idx)
				REG_NODE_COUNT:  cfg_q.node_count  <= pwdata[NCOUNT_W-1:0];
				REG_SOURCE_NODE: cfg_q.source_node <= pwdata[NODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NODE_COUNT:  prdata = DATA_W'(cfg_q.node_count);
			REG_SOURCE_NODE: prdata = DATA_W'(cfg_q.source_node);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/shortest_path_relaxation.sv =====
// bellman-ford shortest path top level: edge load, sort, relaxation sequencer and result output
// loading accepts one edge transaction per cycle while idle; the item with last_edge starts the run
// run: the sort scan visits each stored edge once per node, then up to n passes take each sorted
// edge through REL_RD, REL_A, REL_B, REL_CMP (just REL_RD, REL_A if its from node is unreached)
// each result: OUT_RD, OUT_LD, OUT_SHOW, held on output stall; input stays stalled through the run
// reset clears registers to node count 64, source 0 and an empty edge store; no clearing pass
module shortest_path_relaxation #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spr_pkg::ADDR_W-1:0]          paddr,
	input  logic [spr_pkg::DATA_W-1:0]          pwdata,
	output logic [spr_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                edge_valid,
	input  logic [spr_pkg::NODE_W-1:0]          edge_from,
	input  logic [spr_pkg::NODE_W-1:0]          edge_to,
	input  logic signed [spr_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic                                last_edge,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [spr_pkg::NODE_W-1:0]          node_index,
	output logic signed [spr_pkg::DIST_W-1:0]   distance,
	output logic                                reached,
	output logic                                negative_cycle,
	output logic                                last_result
);
	import spr_pkg::*;

	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int TW = $clog2(MAX_EDGES + 1);
	localparam int NA = $clog2(MAX_NODES);
	localparam int NC = $clog2(MAX_NODES + 1);
	localparam int RW = $bits(edge_rec_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SORT_RD,
		S_SORT_CHK,
		S_INIT,
		S_REL_RD,
		S_REL_A,
		S_REL_B,
		S_REL_CMP,
		S_OUT_RD,
		S_OUT_LD,
		S_OUT_SHOW
	} state_t;

	state_t state_q;

	cfg_t cfg;

	logic [TW-1:0] total_q, e_q, cnt_q, k_q;
	logic [TW-1:0] total_nx, e_nx, k_nx;
	logic [NC-1:0] a_q, round_q, i_q;
	logic [NC-1:0] n_eff, n_m1;
	logic [MAX_NODES-1:0] reached_q;
	logic neg_q;
	logic [NODE_W-1:0] b_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic signed [DIST_W-1:0] cand_q;

	logic [NODE_W-1:0] node_index_q;
	logic signed [DIST_W-1:0] distance_q;
	logic reached_out_q, neg_out_q, last_out_q, out_valid_q;

	logic in_accept, src_ok, match, k_last, check_pass, do_adv;
	logic edge_we, dist_we;
	edge_rec_t edge_wdata, edge_rdata, sort_rdata;
	logic [RW-1:0] edge_rdata_raw, sort_rdata_raw;
	logic [NA-1:0] dist_waddr, dist_raddr;
	logic signed [DIST_W-1:0] dist_wdata, dist_rdata, cand;
	logic improve;

	spr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective node count, clamped to 1..MAX_NODES
	always_comb begin
		if (cfg.node_count == '0) begin
			n_eff = NC'(1);
		end else if (cfg.node_count > NCOUNT_W'(MAX_NODES)) begin
			n_eff = NC'(MAX_NODES);
		end else begin
			n_eff = NC'(cfg.node_count);
		end
	end

	assign n_m1       = n_eff - NC'(1);
	assign src_ok     = NCOUNT_W'(cfg.source_node) < NCOUNT_W'(n_eff);
	assign in_stall   = (state_q != S_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign edge_we    = in_accept && edge_valid && (total_q < TW'(MAX_EDGES));
	assign total_nx   = total_q + TW'(edge_we);
	assign e_nx       = e_q + TW'(1);
	assign k_nx       = k_q + TW'(1);
	assign k_last     = (k_nx == cnt_q);
	assign check_pass = (round_q == n_m1);

	assign edge_wdata.from_node = edge_from;
	assign edge_wdata.to_node   = edge_to;
	assign edge_wdata.weight    = edge_weight;
	assign edge_rdata = edge_rec_t'(edge_rdata_raw);
	assign sort_rdata = edge_rec_t'(sort_rdata_raw);

	// only edges with both endpoints in range enter the sorted store
	assign match = (NCOUNT_W'(edge_rdata.from_node) == NCOUNT_W'(a_q)) &&
		(NCOUNT_W'(edge_rdata.to_node) < NCOUNT_W'(n_eff));

	spr_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (total_q[EA-1:0]),
		.wdata (RW'(edge_wdata)),
		.raddr (e_q[EA-1:0]),
		.rdata (edge_rdata_raw)
	);

	spr_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_sort_ram (
		.clk   (clk),
		.we    (state_q == S_SORT_CHK && match),
		.waddr (cnt_q[EA-1:0]),
		.wdata (edge_rdata_raw),
		.raddr (k_q[EA-1:0]),
		.rdata (sort_rdata_raw)
	);

	always_comb begin
		dist_we    = 1'b0;
		dist_waddr = b_q[NA-1:0];
		dist_wdata = cand_q;
		if (state_q == S_INIT) begin
			dist_we    = src_ok;
			dist_waddr = cfg.source_node[NA-1:0];
			dist_wdata = '0;
		end else if (state_q == S_REL_CMP) begin
			dist_we = improve && !check_pass;
		end
	end

	always_comb begin
		case (state_q)
			S_REL_A:  dist_raddr = sort_rdata.from_node[NA-1:0];
			S_REL_B:  dist_raddr = b_q[NA-1:0];
			S_OUT_RD: dist_raddr = i_q[NA-1:0];
			default:  dist_raddr = '0;
		endcase
	end

	spr_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	spr_relax_unit u_relax (
		.dist_a    (dist_rdata),
		.weight    (w_q),
		.cand      (cand),
		.cand_in   (cand_q),
		.dist_b    (dist_rdata),
		.reached_b (reached_q[b_q[NA-1:0]]),
		.improve   (improve)
	);

	always_comb begin
		do_adv = 1'b0;
		if (state_q == S_REL_A) begin
			do_adv = !reached_q[sort_rdata.from_node[NA-1:0]];
		end else if (state_q == S_REL_CMP) begin
			do_adv = !(improve && check_pass);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			e_q         <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			a_q         <= '0;
			round_q     <= '0;
			i_q         <= '0;
			reached_q   <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						total_q <= total_nx;
						if (last_edge) begin
							e_q   <= '0;
							a_q   <= '0;
							cnt_q <= '0;
							state_q <= (total_nx == '0) ? S_INIT : S_SORT_RD;
						end
					end
				end
				S_SORT_RD: begin
					state_q <= S_SORT_CHK;
				end
				S_SORT_CHK: begin
					if (match) begin
						cnt_q <= cnt_q + TW'(1);
					end
					if (e_nx < total_q) begin
						e_q     <= e_nx;
						state_q <= S_SORT_RD;
					end else begin
						e_q <= '0;
						if (a_q != n_m1) begin
							a_q     <= a_q + NC'(1);
							state_q <= S_SORT_RD;
						end else begin
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					reached_q <= '0;
					if (src_ok) begin
						reached_q[cfg.source_node[NA-1:0]] <= 1'b1;
					end
					neg_q   <= 1'b0;
					round_q <= '0;
					k_q     <= '0;
					i_q     <= '0;
					state_q <= (!src_ok || cnt_q == '0) ? S_OUT_RD : S_REL_RD;
				end
				S_REL_RD: begin
					state_q <= S_REL_A;
				end
				S_REL_A: begin
					b_q <= sort_rdata.to_node;
					w_q <= sort_rdata.weight;
					if (!do_adv) begin
						state_q <= S_REL_B;
					end
				end
				S_REL_B: begin
					cand_q  <= cand;
					state_q <= S_REL_CMP;
				end
				S_REL_CMP: begin
					if (improve) begin
						if (check_pass) begin
							neg_q   <= 1'b1;
							i_q     <= '0;
							state_q <= S_OUT_RD;
						end else begin
							reached_q[b_q[NA-1:0]] <= 1'b1;
						end
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT_LD;
				end
				S_OUT_LD: begin
					node_index_q  <= NODE_W'(i_q);
					reached_out_q <= reached_q[i_q[NA-1:0]];
					distance_q    <= reached_q[i_q[NA-1:0]] ? dist_rdata : '0;
					neg_out_q     <= neg_q;
					last_out_q    <= (i_q == n_m1);
					out_valid_q   <= 1'b1;
					state_q       <= S_OUT_SHOW;
				end
				S_OUT_SHOW: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (i_q == n_m1) begin
							total_q <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + NC'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// next edge of the pass, or next pass, or on to the results
			if (do_adv) begin
				if (!k_last) begin
					k_q     <= k_nx;
					state_q <= S_REL_RD;
				end else begin
					k_q <= '0;
					if (check_pass) begin
						i_q     <= '0;
						state_q <= S_OUT_RD;
					end else begin
						round_q <= round_q + NC'(1);
						state_q <= S_REL_RD;
					end
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign node_index     = node_index_q;
	assign distance       = distance_q;
	assign reached        = reached_out_q;
	assign negative_cycle = neg_out_q;
	assign last_result    = last_out_q;

	a_no_out_while_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("result shown while input is ready");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(MAX_EDGES))
		else $error("edge count beyond store depth");

	a_sorted_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (cnt_q <= total_q))
		else $error("sorted edge count exceeds stored edges");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_result) |=> (!in_stall && total_q == '0))
		else $error("block not ready and empty after final result transaction");

endmodule

// ===== tb/spr_checker.sv =====
// checker for the shortest path block: tracks config, predicts results per run and compares
`timescale 1ns / 1ps
module spr_checker #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spr_pkg::ADDR_W-1:0]          paddr,
	input  logic [spr_pkg::DATA_W-1:0]          pwdata,
	input  logic [spr_pkg::DATA_W-1:0]          prdata,
	input  logic                                pready,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                edge_valid,
	input  logic [spr_pkg::NODE_W-1:0]          edge_from,
	input  logic [spr_pkg::NODE_W-1:0]          edge_to,
	input  logic signed [spr_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic                                last_edge,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [spr_pkg::NODE_W-1:0]          node_index,
	input  logic signed [spr_pkg::DIST_W-1:0]   distance,
	input  logic                                reached,
	input  logic                                negative_cycle,
	input  logic                                last_result,
	output int                                  failures,
	output int                                  pending
);
	import spr_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0]        node;
		logic signed [DIST_W-1:0] dist_val;
		logic                     reach;
		logic                     neg_cyc;
		logic                     tail;
	} node_result_t;

	localparam longint DIST_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint DIST_LO = -DIST_HI - 1;

	cfg_t         cfg;
	edge_rec_t    edge_list [$];
	int           visit_q [$];
	longint       node_dist [MAX_NODES];
	bit           node_seen [MAX_NODES];
	node_result_t expected_q [$];
	node_result_t got_res;
	node_result_t want_res;
	logic [DATA_W-1:0] want_rd;
	int           mismatches;

	// one sweep over the visit order; with commit clear it only reports a possible improvement
	function automatic bit sweep(input bit commit);
		int     k;
		int     a;
		int     b;
		longint cand;
		for (k = 0; k < visit_q.size(); k++) begin
			a = edge_list[visit_q[k]].from_node;
			b = edge_list[visit_q[k]].to_node;
			if (node_seen[a]) begin
				cand = node_dist[a] + longint'(edge_list[visit_q[k]].weight);
				if (cand > DIST_HI)
					cand = DIST_HI;
				else if (cand < DIST_LO)
					cand = DIST_LO;
				if (!node_seen[b] || node_dist[b] > cand) begin
					if (!commit)
						return 1'b1;
					node_dist[b] = cand;
					node_seen[b] = 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic void predict_distances();
		int           n;
		int           s;
		int           e;
		bit           neg;
		node_result_t res;
		n = cfg.node_count;
		if (n < 1)
			n = 1;
		if (n > MAX_NODES)
			n = MAX_NODES;
		// stable order by source node, edges with an endpoint out of range left out
		visit_q.delete();
		for (s = 0; s < n; s++)
			for (e = 0; e < edge_list.size(); e++)
				if (edge_list[e].from_node == s && edge_list[e].to_node < n)
					visit_q.push_back(e);
		for (s = 0; s < MAX_NODES; s++) begin
			node_seen[s] = 1'b0;
			node_dist[s] = 0;
		end
		neg = 1'b0;
		if (cfg.source_node < n) begin
			node_seen[cfg.source_node] = 1'b1;
			for (s = 1; s < n; s++)
				void'(sweep(1'b1));
			neg = sweep(1'b0);
		end
		for (s = 0; s < n; s++) begin
			res.node     = NODE_W'(s);
			res.dist_val = node_seen[s] ? node_dist[s][DIST_W-1:0] : '0;
			res.reach    = node_seen[s];
			res.neg_cyc  = neg;
			res.tail     = (s == n - 1);
			expected_q.push_back(res);
		end
		edge_list.delete();
	endfunction

	task automatic report_result(input string why, input node_result_t got,
			input node_result_t want);
		if (mismatches < 10) begin
			$display("%s: node %0d distance %0d reached %0b negcyc %0b last %0b", why,
				got.node, got.dist_val, got.reach, got.neg_cyc, got.tail);
			$display("  expected node %0d distance %0d reached %0b negcyc %0b last %0b",
				want.node, want.dist_val, want.reach, want.neg_cyc, want.tail);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{node_count: NODE_COUNT_RST, source_node: SOURCE_NODE_RST};
			edge_list.delete();
			expected_q.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr >> 2))
						REG_NODE_COUNT:  cfg.node_count  = pwdata[NCOUNT_W-1:0];
						REG_SOURCE_NODE: cfg.source_node = pwdata[NODE_W-1:0];
						default: ;
					endcase
				end else begin
					want_rd = (reg_idx_t'(paddr >> 2) == REG_NODE_COUNT) ?
						DATA_W'(cfg.node_count) : DATA_W'(cfg.source_node);
					if (prdata !== want_rd) begin
						if (mismatches < 10)
							$display("register read at %0d: got %h expected %h",
								paddr, prdata, want_rd);
						mismatches++;
					end
				end
			end
			// input transaction: store the edge, a last item kicks off the run
			if (in_valid && !in_stall) begin
				if (edge_valid && edge_list.size() < MAX_EDGES)
					edge_list.push_back('{from_node: edge_from, to_node: edge_to,
						weight: edge_weight});
				if (last_edge)
					predict_distances();
			end
			if (out_valid && !out_stall) begin
				got_res = '{node: node_index, dist_val: distance, reach: reached,
					neg_cyc: negative_cycle, tail: last_result};
				if (expected_q.size() == 0) begin
					report_result("result with nothing expected", got_res, '0);
				end else begin
					want_res = expected_q.pop_front();
					if (got_res !== want_res)
						report_result("result mismatch", got_res, want_res);
				end
			end
		end
		failures <= mismatches;
		pending  <= expected_q.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// testbench top: stimulus, register setup and verdict for the shortest path block
`timescale 1ns / 1ps
module tb_top;
	import spr_pkg::*;

	// edge store depth and node count of the block under test
	localparam int EDGE_CAP     = 1024;
	localparam int NODE_CAP     = 64;
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int RANDOM_ITEMS = 450;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [ADDR_W-1:0]            paddr = '0;
	logic [DATA_W-1:0]            pwdata = '0;
	logic [DATA_W-1:0]            prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         edge_valid = 1'b0;
	logic [NODE_W-1:0]            edge_from = '0;
	logic [NODE_W-1:0]            edge_to = '0;
	logic signed [WEIGHT_W-1:0]   edge_weight = '0;
	logic                         last_edge = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [NODE_W-1:0]            node_index;
	logic signed [DIST_W-1:0]     distance;
	logic                         reached;
	logic                         negative_cycle;
	logic                         last_result;
	int                           failures;
	int                           pending;

	bit                           quiet;
	int                           hold_cycles;
	int                           live_nodes;
	logic [NODE_W-1:0]            live_src;
	int                           random_items;

	shortest_path_relaxation #(.MAX_NODES(NODE_CAP), .MAX_EDGES(EDGE_CAP)) i_dut (.*);

	spr_checker #(.MAX_NODES(NODE_CAP), .MAX_EDGES(EDGE_CAP)) i_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin : watchdog
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random wait per transaction, or one long hold when requested
	initial begin : result_sink
		int pause;
		pause = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				pause = hold_cycles;
				hold_cycles = 0;
			end else if (out_valid && !out_stall) begin
				pause = quiet ? 0 : $urandom_range(4);
			end
			if (pause > 0) begin
				out_stall <= 1'b1;
				pause--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_edge(input bit carries, input logic [NODE_W-1:0] src,
			input logic [NODE_W-1:0] dst, input logic [WEIGHT_W-1:0] w, input bit ends);
		int gap;
		gap = quiet ? 0 : $urandom_range(4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		edge_valid  <= carries;
		edge_from   <= src;
		edge_to     <= dst;
		edge_weight <= w;
		last_edge   <= ends;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// wait until every expected result is in; the block empties its edge store as the last result is taken
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_access(input reg_idx_t idx, input bit wr, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [NCOUNT_W-1:0] count, input logic [NODE_W-1:0] src);
		drain_results();
		cfg_access(REG_NODE_COUNT, 1'b1, DATA_W'(count));
		cfg_access(REG_SOURCE_NODE, 1'b1, DATA_W'(src));
		cfg_access(REG_NODE_COUNT, 1'b0, '0);
		cfg_access(REG_SOURCE_NODE, 1'b0, '0);
		live_nodes = (count == 0) ? 1 : (count > NODE_CAP) ? NODE_CAP : count;
		live_src   = src;
	endtask

	// one graph: mostly in-range edges with small weights, some wide weights and stray items
	task automatic random_run();
		int                  cnt;
		int                  k;
		bit                  bare_end;
		logic [NODE_W-1:0]   a;
		logic [NODE_W-1:0]   b;
		logic [WEIGHT_W-1:0] w;
		cnt      = ($urandom_range(7) == 0) ? $urandom_range(16, 32) : $urandom_range(1, 10);
		bare_end = ($urandom_range(3) == 0);
		for (k = 0; k < cnt; k++) begin
			if ($urandom_range(15) == 0)
				push_edge(1'b0, NODE_W'($urandom), NODE_W'($urandom), $urandom, 1'b0);
			if (k == 0 && $urandom_range(3) != 0)
				a = live_src;
			else if ($urandom_range(9) == 0)
				a = NODE_W'($urandom);
			else
				a = NODE_W'($urandom_range(live_nodes - 1));
			b = ($urandom_range(9) == 0) ? NODE_W'($urandom) :
				NODE_W'($urandom_range(live_nodes - 1));
			w = ($urandom_range(4) == 0) ? $urandom : WEIGHT_W'($urandom_range(60) - 12);
			push_edge(1'b1, a, b, w, (k == cnt - 1) && !bare_end);
		end
		if (bare_end)
			push_edge(1'b0, NODE_W'($urandom), NODE_W'($urandom), $urandom, 1'b1);
		random_items += cnt + (bare_end ? 1 : 0);
	endtask

	initial begin : stimulus
		int n_set;
		int src_set;
		int live;
		bit hold_done;
		quiet        = 1'b0;
		hold_cycles  = 0;
		live_nodes   = NODE_CAP;
		live_src     = '0;
		random_items = 0;
		hold_done    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: extreme weights and skipped items
		push_edge(1'b0, 6'd9, 6'd17, 32'h1234_5678, 1'b0);
		push_edge(1'b1, 6'd0, 6'd1, 32'h7FFF_FFFF, 1'b0);
		push_edge(1'b1, 6'd1, 6'd2, 32'h7FFF_FFFF, 1'b0);
		push_edge(1'b1, 6'd2, 6'd3, 32'h8000_0000, 1'b0);
		push_edge(1'b1, 6'd63, 6'd62, 32'hFFFF_FFFF, 1'b0);
		push_edge(1'b1, 6'd3, 6'd63, 32'd5, 1'b0);
		push_edge(1'b1, 6'd0, 6'd3, 32'd10, 1'b0);
		push_edge(1'b0, 6'd63, 6'd0, 32'h0, 1'b1);

		// reachable negative cycle plus edges with out of range endpoints
		set_config(7'd4, 6'd2);
		push_edge(1'b1, 6'd2, 6'd3, 32'd1, 1'b0);
		push_edge(1'b1, 6'd3, 6'd1, 32'hFFFF_FFFD, 1'b0);
		push_edge(1'b1, 6'd1, 6'd2, 32'd1, 1'b0);
		push_edge(1'b1, 6'd0, 6'd1, 32'd3, 1'b0);
		push_edge(1'b1, 6'd5, 6'd1, 32'd1, 1'b0);
		push_edge(1'b1, 6'd1, 6'd40, 32'd1, 1'b0);
		push_edge(1'b1, 6'd3, 6'd0, 32'h8000_0000, 1'b1);

		// zero nodes acts as one node
		set_config(7'd0, 6'd0);
		push_edge(1'b1, 6'd0, 6'd0, 32'hFFFF_FFFF, 1'b1);

		// source beyond the node count: nothing reached
		set_config(7'd3, 6'd63);
		push_edge(1'b1, 6'd63, 6'd0, 32'd1, 1'b0);
		push_edge(1'b1, 6'd0, 6'd1, 32'd2, 1'b0);
		push_edge(1'b0, 6'd0, 6'd0, 32'd0, 1'b1);

		// node count above the limit acts as the limit
		set_config(7'd127, 6'd0);
		push_edge(1'b1, 6'd0, 6'd63, 32'hFFFF_FFF9, 1'b1);

		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0:       n_set = 1;
				1:       n_set = NODE_CAP;
				2:       n_set = 0;
				3:       n_set = $urandom_range(NODE_CAP + 1, 127);
				default: n_set = $urandom_range(2, 10);
			endcase
			live    = (n_set == 0) ? 1 : (n_set > NODE_CAP) ? NODE_CAP : n_set;
			src_set = ($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(live - 1);
			set_config(NCOUNT_W'(n_set), NODE_W'(src_set));
			quiet = ($urandom_range(4) == 0);
			// long output hold while input keeps coming, so the block backs up
			if (!hold_done && random_items > 100) begin
				hold_cycles = 400;
				hold_done   = 1'b1;
			end
			repeat ($urandom_range(2, 5))
				random_run();
		end

		drain_results();
		repeat (30) @(posedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/spr_pkg.sv
rtl/core/spr_ram.sv
rtl/core/spr_relax_unit.sv
rtl/core/spr_apb_regs.sv
rtl/core/shortest_path_relaxation.sv
tb/spr_checker.sv
tb/tb_top.sv
